@@ design/kdmc_pkg.sv @@
// ----------------------------------------------------------------------------
// kdmc_pkg
// shared constants and types for the keypad debounce and mode controller
// ----------------------------------------------------------------------------
package kdmc_pkg;

    localparam int NUM_BUTTONS = 8;

    localparam int B_POWER  = 0;
    localparam int B_UP     = 1;
    localparam int B_DOWN   = 2;
    localparam int B_LEFT   = 3;
    localparam int B_RIGHT  = 4;
    localparam int B_MANUAL = 5;
    localparam int B_NAV    = 6;
    localparam int B_ANCHOR = 7;

    localparam int DEBOUNCE_W = 8;
    localparam int LOCK_W     = 16;
    localparam int SETTLE_W   = 9;
    localparam int ELAPSED_W  = 8;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd30;
    localparam logic [LOCK_W-1:0]     LOCK_RESET     = 16'd300;
    localparam logic [SETTLE_W-1:0]   SETTLE_MAX     = 9'd511;
    localparam logic [LOCK_W-1:0]     UPTIME_MAX     = 16'hFFFF;

    typedef enum logic {
        CFG_DEBOUNCE = 1'b0,
        CFG_LOCK     = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_DIRECT  = 2'd0,
        MODE_HEADING = 2'd1,
        MODE_HOLD    = 2'd2
    } mode_t;

    typedef struct packed {
        logic [NUM_BUTTONS-1:0] stable;
        logic [NUM_BUTTONS-1:0] prev;
        logic                   unlocked;
    } btn_state_t;

    typedef struct packed {
        logic       turn_right;
        logic       turn_left;
        logic       speed_down;
        logic       speed_up;
        logic       power_on;
        logic [1:0] mode;
        logic       send;
    } result_t;

endpackage

@@ design/kdmc_debounce.sv @@
// ----------------------------------------------------------------------------
// kdmc_debounce
// per-button settle counters, stable levels, uptime and mode-button lock
// ----------------------------------------------------------------------------
module kdmc_debounce
    import kdmc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  fire,
    input  logic [7:0]            pin_levels,
    input  logic [ELAPSED_W-1:0]  elapsed_ms,
    input  logic [DEBOUNCE_W-1:0] debounce_ms,
    input  logic [LOCK_W-1:0]     lock_ms,
    output btn_state_t            btn_next
);

    logic [NUM_BUTTONS-1:0] raw_reg, raw_next;
    logic [NUM_BUTTONS-1:0] stable_reg, stable_next;
    logic [NUM_BUTTONS-1:0] prev_reg, prev_next;
    logic [SETTLE_W-1:0]    count_reg [NUM_BUTTONS];
    logic [SETTLE_W-1:0]    count_next [NUM_BUTTONS];
    logic [LOCK_W-1:0]      uptime_reg, uptime_next;
    logic                   locked_reg, locked_next;
    logic [LOCK_W:0]        uptime_sum;

    always_comb begin
        logic [SETTLE_W:0] csum;
        logic              reading;
        uptime_sum  = {1'b0, uptime_reg} + {{(LOCK_W + 1 - ELAPSED_W){1'b0}}, elapsed_ms};
        uptime_next = uptime_sum[LOCK_W] ? UPTIME_MAX : uptime_sum[LOCK_W-1:0];
        raw_next    = raw_reg;
        stable_next = stable_reg;
        prev_next   = prev_reg;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            reading = ~pin_levels[i];
            csum = {1'b0, count_reg[i]} + {{(SETTLE_W + 1 - ELAPSED_W){1'b0}}, elapsed_ms};
            if (reading != raw_reg[i]) begin
                raw_next[i]   = reading;
                count_next[i] = '0;
            end else begin
                count_next[i] = csum[SETTLE_W] ? SETTLE_MAX : csum[SETTLE_W-1:0];
            end
            if (count_next[i] > {1'b0, debounce_ms}) begin
                prev_next[i]   = stable_reg[i];
                stable_next[i] = raw_next[i];
            end
        end
        locked_next = locked_reg;
        if (locked_reg && (uptime_next > lock_ms)) begin
            prev_next   = stable_next;
            locked_next = 1'b0;
        end
        btn_next.stable   = stable_next;
        btn_next.prev     = prev_next;
        btn_next.unlocked = ~locked_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_reg    <= '0;
            stable_reg <= '0;
            prev_reg   <= '0;
            uptime_reg <= '0;
            locked_reg <= 1'b1;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                count_reg[i] <= '0;
            end
        end else if (fire) begin
            raw_reg    <= raw_next;
            stable_reg <= stable_next;
            prev_reg   <= prev_next;
            uptime_reg <= uptime_next;
            locked_reg <= locked_next;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                count_reg[i] <= count_next[i];
            end
        end
    end

    // once the lock lifts it never returns
    a_lock_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        !locked_reg |=> !locked_reg)
        else $error("lock came back after release");

    // uptime only grows
    a_uptime_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> uptime_reg >= $past(uptime_reg))
        else $error("uptime went backwards");

    // release of the lock leaves no pending press edges
    a_lock_baseline: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(locked_reg) |-> prev_reg == stable_reg)
        else $error("press baseline not taken at unlock");

endmodule

@@ design/kdmc_control.sv @@
// ----------------------------------------------------------------------------
// kdmc_control
// mode selection, motor toggle and drive request resolution
// ----------------------------------------------------------------------------
module kdmc_control
    import kdmc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  btn_state_t btn,
    output result_t    result
);

    mode_t      mode_reg, mode_next;
    logic       motor_reg, motor_next;
    logic [4:0] sent_reg, sent_next;

    always_comb begin
        logic [NUM_BUTTONS-1:0] edge_det;
        logic                   changed;
        logic                   li;
        logic                   ri;
        logic [4:0]             drive;
        edge_det   = btn.stable & ~btn.prev;
        changed    = 1'b0;
        mode_next  = mode_reg;
        motor_next = motor_reg;
        sent_next  = sent_reg;
        li         = 1'b0;
        ri         = 1'b0;
        drive      = sent_reg;
        if (btn.unlocked) begin
            if (edge_det[B_MANUAL]) begin
                mode_next = MODE_DIRECT;
                changed   = 1'b1;
            end
            if (edge_det[B_NAV]) begin
                mode_next = MODE_HEADING;
                changed   = 1'b1;
            end
            if (edge_det[B_ANCHOR]) begin
                mode_next = MODE_HOLD;
                changed   = 1'b1;
            end
        end
        case (mode_next) inside
            MODE_DIRECT, MODE_HEADING: begin
                if (edge_det[B_POWER]) begin
                    motor_next   = ~motor_reg;
                    sent_next[0] = ~motor_reg;
                    changed      = 1'b1;
                end
                if (mode_next == MODE_DIRECT) begin
                    li = btn.stable[B_LEFT];
                    ri = btn.stable[B_RIGHT];
                end else begin
                    li = edge_det[B_LEFT];
                    ri = edge_det[B_RIGHT];
                end
                // swapped mapping on both pairs
                drive = {li & ~ri, ri & ~li,
                         btn.stable[B_UP] & ~btn.stable[B_DOWN],
                         btn.stable[B_DOWN] & ~btn.stable[B_UP],
                         sent_next[0]};
                if (drive != sent_next) begin
                    changed = 1'b1;
                end
                sent_next = drive;
            end
            default: begin
            end
        endcase
        result.send       = changed;
        result.mode       = mode_next;
        result.power_on   = sent_next[0];
        result.speed_up   = sent_next[1];
        result.speed_down = sent_next[2];
        result.turn_left  = sent_next[3];
        result.turn_right = sent_next[4];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_DIRECT;
            motor_reg <= 1'b1;
            sent_reg  <= '0;
        end else if (fire) begin
            mode_reg  <= mode_next;
            motor_reg <= motor_next;
            sent_reg  <= sent_next;
        end
    end

endmodule

@@ design/keypad_debounce_mode_controller_unit.sv @@
// ----------------------------------------------------------------------------
// keypad_debounce_mode_controller_unit
// debounced keypad with lock-out, mode selection and drive requests
// ----------------------------------------------------------------------------
// Takes one word per clock and returns one result word for each: a word is
// captured in an input register, then the debounce and mode logic updates its
// state and loads the result register. The state feedback through that logic
// is what fixes the rate at one word per cycle; a result held by m_tready low
// holds the input register and so stops intake. Registers are written through
// the cfg port (index 0 debounce time, index 1 lock time); the user must write
// them only while the block is idle, the block itself does not enforce it.
module keypad_debounce_mode_controller_unit
    import kdmc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // pin_levels[7:0], elapsed_ms[15:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // send, mode[2:1], power_on, speed_up,
                                   // speed_down, turn_left, turn_right
);

    logic [DEBOUNCE_W-1:0] debounce_reg;
    logic [LOCK_W-1:0]     lock_reg;
    logic                  in_valid_reg;
    logic [7:0]            pins_reg;
    logic [ELAPSED_W-1:0]  elapsed_reg;
    logic                  out_valid_reg;
    result_t               out_reg;
    logic                  fire;
    btn_state_t            btn_next;
    result_t               result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
            lock_reg     <= LOCK_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_DEBOUNCE: debounce_reg <= cfg_data[DEBOUNCE_W-1:0];
                CFG_LOCK:     lock_reg     <= cfg_data[LOCK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            pins_reg    <= s_tdata[7:0];
            elapsed_reg <= s_tdata[15:8];
        end
    end

    kdmc_debounce u_debounce (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .pin_levels  (pins_reg),
        .elapsed_ms  (elapsed_reg),
        .debounce_ms (debounce_reg),
        .lock_ms     (lock_reg),
        .btn_next    (btn_next)
    );

    kdmc_control u_control (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .btn     (btn_next),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.turn_right, out_reg.turn_left, out_reg.speed_down,
                       out_reg.speed_up, out_reg.power_on, out_reg.mode, out_reg.send};

    // mode code three is never produced
    a_mode_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:1] != 2'b11)
        else $error("invalid mode code on output");

    // a held input word with a blocked output stops intake
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("intake while pipeline blocked");

    // every processed word shows up as a result
    a_fire_out: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_tvalid)
        else $error("processed word lost");

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks the keypad debounce and mode controller against its own predictor.
// Button samples are streamed in with random gaps and the results are taken
// with random stalls. Each result word is compared field by field with the
// prediction worked out when its sample was accepted. The run steps through
// the lock-out period, a lock time that never ends, the unlock and every
// mode, and then random press sequences under several register settings.
// ----------------------------------------------------------------------------
module testbench;
    import kdmc_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    cfg_index_t  cfg_index;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // pin_levels[7:0], elapsed_ms[15:8]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // send, mode[2:1], power_on, speed_up,
                            // speed_down, turn_left, turn_right

    keypad_debounce_mode_controller_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // predictor state
    int         kp_debounce = DEBOUNCE_RESET;
    int         kp_lock     = LOCK_RESET;
    int         kp_uptime   = 0;
    int         kp_settle [NUM_BUTTONS] = '{default: 0};
    logic [7:0] kp_raw      = '0;
    logic [7:0] kp_stable   = '0;
    logic [7:0] kp_prev     = '0;
    bit         kp_locked   = 1'b1;
    mode_t      kp_mode     = MODE_DIRECT;
    logic       kp_motor    = 1'b1;
    result_t    kp_sent     = '0;

    result_t expected_ctrl [$];
    int      mismatch_count = 0;
    int      word_count = 0;
    bit      no_idle = 1'b0;
    result_t got_word;
    result_t want_word;

    function automatic result_t keypad_next(input logic [7:0] pins, input logic [7:0] el);
        result_t    r;
        result_t    nxt;
        logic [7:0] pressed;
        logic [7:0] edges;
        logic       up, dn, lf, rt;
        logic       chg;
        int         sum;
        int         cnt;
        chg = 1'b0;
        pressed = ~pins;
        sum = kp_uptime + el;
        kp_uptime = (sum > UPTIME_MAX) ? UPTIME_MAX : sum;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (pressed[b] != kp_raw[b]) begin
                kp_raw[b] = pressed[b];
                kp_settle[b] = 0;
            end else begin
                cnt = kp_settle[b] + el;
                kp_settle[b] = (cnt > SETTLE_MAX) ? SETTLE_MAX : cnt;
            end
            if (kp_settle[b] > kp_debounce) begin
                kp_prev[b] = kp_stable[b];
                kp_stable[b] = kp_raw[b];
            end
        end
        // press baseline taken at unlock
        if (kp_locked && kp_uptime > kp_lock) begin
            kp_prev = kp_stable;
            kp_locked = 1'b0;
        end
        edges = kp_stable & ~kp_prev;
        if (!kp_locked) begin
            if (edges[B_MANUAL]) begin
                kp_mode = MODE_DIRECT;
                chg = 1'b1;
            end
            if (edges[B_NAV]) begin
                kp_mode = MODE_HEADING;
                chg = 1'b1;
            end
            if (edges[B_ANCHOR]) begin
                kp_mode = MODE_HOLD;
                chg = 1'b1;
            end
        end
        if (kp_mode == MODE_DIRECT || kp_mode == MODE_HEADING) begin
            if (edges[B_POWER]) begin
                kp_motor = ~kp_motor;
                kp_sent.power_on = kp_motor;
                chg = 1'b1;
            end
            up = kp_stable[B_UP];
            dn = kp_stable[B_DOWN];
            if (kp_mode == MODE_DIRECT) begin
                lf = kp_stable[B_LEFT];
                rt = kp_stable[B_RIGHT];
            end else begin
                lf = edges[B_LEFT];
                rt = edges[B_RIGHT];
            end
            // swapped mapping of both pairs
            nxt = kp_sent;
            nxt.speed_up   = dn & ~up;
            nxt.speed_down = up & ~dn;
            nxt.turn_left  = rt & ~lf;
            nxt.turn_right = lf & ~rt;
            if (nxt != kp_sent) begin
                kp_sent = nxt;
                chg = 1'b1;
            end
        end
        r = kp_sent;
        r.send = chg;
        r.mode = kp_mode;
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("word %0d: %s expected %0d, got %0d", word_count, name, want, got);
        end
    endfunction

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    // result sink with random stalls
    initial begin : result_sink
        int hold_cycles;
        m_tready = 1'b0;
        forever begin
            hold_cycles = no_idle ? 0 : $urandom_range(0, 9);
            @(negedge aclk);
            if (hold_cycles != 0) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_word = result_t'(m_tdata);
            if (expected_ctrl.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("word %0d: unexpected result %h", word_count, m_tdata);
            end else begin
                want_word = expected_ctrl.pop_front();
                check_field("send", want_word.send, got_word.send);
                check_field("mode", want_word.mode, got_word.mode);
                check_field("power_on", want_word.power_on, got_word.power_on);
                check_field("speed_up", want_word.speed_up, got_word.speed_up);
                check_field("speed_down", want_word.speed_down, got_word.speed_down);
                check_field("turn_left", want_word.turn_left, got_word.turn_left);
                check_field("turn_right", want_word.turn_right, got_word.turn_right);
            end
            word_count++;
        end
    end

    task automatic send_sample(input logic [7:0] pins, input logic [7:0] el);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {el, pins};
        do @(posedge aclk); while (!s_tready);
        expected_ctrl.push_back(keypad_next(pins, el));
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_ctrl.size() != 0) @(posedge aclk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [15:0] value);
        drain_results();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DEBOUNCE: kp_debounce = value[7:0];
            CFG_LOCK:     kp_lock = value;
        endcase
    endtask

    // reset values, uptime kept under the lock time
    task automatic test_locked_defaults();
        send_sample(8'hFF, 8'd0);
        send_sample(8'hFE, 8'd10);
        send_sample(8'hFE, 8'd30);
        send_sample(8'hFE, 8'd1);
        send_sample(8'hFF, 8'd40);
        send_sample(8'hFF, 8'd31);
        send_sample(8'hBF, 8'd5);
        send_sample(8'hBF, 8'd31);
        send_sample(8'hBD, 8'd1);
        send_sample(8'hBD, 8'd31);
        send_sample(8'hB9, 8'd1);
        send_sample(8'hB9, 8'd31);
    endtask

    // uptime saturates and the lock stays on
    task automatic test_lock_never_ends();
        write_register(CFG_LOCK, 16'hFFFF);
        write_register(CFG_DEBOUNCE, 16'd0);
        repeat (300) send_sample(8'($urandom_range(0, 255)), 8'd255);
        send_sample(8'h7F, 8'd255);
        send_sample(8'h7F, 8'd255);
    endtask

    task automatic test_unlock_and_modes();
        write_register(CFG_LOCK, 16'd60000);
        send_sample(8'hBF, 8'd0);
        send_sample(8'hBF, 8'd1);
        send_sample(8'hAF, 8'd1);
        send_sample(8'hAF, 8'd1);
        send_sample(8'hFE, 8'd1);
        send_sample(8'hFE, 8'd1);
        send_sample(8'hBF, 8'd1);
        send_sample(8'hBF, 8'd1);
        send_sample(8'hFF, 8'd1);
        send_sample(8'h9F, 8'd1);
        send_sample(8'h9F, 8'd1);
        send_sample(8'h7E, 8'd1);
        send_sample(8'h7E, 8'd1);
        send_sample(8'h00, 8'd1);
    endtask

    task automatic test_random_presses(input int debounce, input int lock, input int el_max,
                                       input bit quiet, input int n);
        int         done;
        int         hold;
        int         bit_sel;
        bit         paused;
        logic [7:0] pattern;
        logic [7:0] pins;
        write_register(CFG_DEBOUNCE, 16'(debounce));
        write_register(CFG_LOCK, 16'(lock));
        no_idle = quiet;
        done = 0;
        paused = 1'b0;
        while (done < n) begin
            if ($urandom_range(0, 4) == 0) begin
                send_sample(8'($urandom_range(0, 255)), 8'($urandom_range(0, el_max)));
                done++;
            end else begin
                pattern = 8'hFF;
                repeat ($urandom_range(0, 2)) pattern[$urandom_range(0, 7)] = 1'b0;
                hold = $urandom_range(1, 8);
                repeat (hold) begin
                    // occasional contact bounce on one button
                    pins = pattern;
                    if ($urandom_range(0, 7) == 0) begin
                        bit_sel = $urandom_range(0, 7);
                        pins[bit_sel] = ~pins[bit_sel];
                    end
                    send_sample(pins, 8'($urandom_range(0, el_max)));
                    done++;
                end
            end
            if (!paused && done >= n / 2) begin
                drain_results();
                paused = 1'b1;
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_DEBOUNCE;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_locked_defaults();
        test_lock_never_ends();
        test_unlock_and_modes();
        test_random_presses(0, 0, 6, 1'b0, 160);
        test_random_presses($urandom_range(1, 40), 60000, 40, 1'b0, 160);
        test_random_presses(255, $urandom_range(0, 60000), 255, 1'b0, 160);
        test_random_presses($urandom_range(0, 255), $urandom_range(0, 60000), 100, 1'b1, 160);
        test_random_presses(10, $urandom_range(0, 60000), 20, 1'b0, 160);
        test_random_presses($urandom_range(0, 60), $urandom_range(0, 60000), 255, 1'b0, 160);

        drain_results();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && expected_ctrl.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/kdmc_pkg.sv
design/kdmc_debounce.sv
design/kdmc_control.sv
design/keypad_debounce_mode_controller_unit.sv
dv/testbench.sv
